// File: sv/plst_pkg.sv
// Shared types and constants for the positional list store.
package plst_pkg;

  // Fixed field widths of the command and result ports
  localparam int ITEM_W  = 16;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_ERASE   = 2'd1;
  localparam logic [1:0] FUNC_DISPLAY = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_POS = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

// File: sv/positional_list_store.sv
// Top level of the positional list store: sequencer, entry memory and result register.
//
// Ordered list of up to CAPACITY entries held in a single-port-write,
// single-port-read memory with a registered read. A command transaction is
// taken when start is high and busy is low; busy stays high while the
// sequencer works. Every entry that moves is read from memory, then written
// one slot over: an insert shifts the entries from position p upward one
// slot, an erase shifts those above p down one slot, and a display reads each
// element before emitting it. Rejected commands (full, bad position, empty, unused
// code) never raise busy. Each result sits on the result ports for exactly one cycle
// with done high, the cycle after the edge that produced it; the receiver
// cannot stall, so results must be taken when shown. A display gives one
// result per element, last set on the final one; every other command gives
// one result with last set. The final result appears in the first cycle
// busy is low again, so a new command may be issued in that same cycle.
// Entry contents are not cleared by reset; only entries below the count
// are ever read.
module positional_list_store #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [plst_pkg::POS_W-1:0]    position,
  input  logic [plst_pkg::ITEM_W-1:0]   item,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [plst_pkg::COUNT_W-1:0]  count,
  output logic                          is_empty,
  output logic [plst_pkg::ITEM_W-1:0]   element,
  output logic                          last
);
  import plst_pkg::*;

  // Address width of the entry memory, count width holds 0..CAPACITY
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  // Common width for comparing the position field against the count
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_RD  = 7'b0000010,
    S_INS_WR  = 7'b0000100,
    S_ERS_RD  = 7'b0001000,
    S_ERS_WR  = 7'b0010000,
    S_DSP_RD  = 7'b0100000,
    S_DSP_OUT = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         cnt, cnt_next;       // elements held
  logic [CW-1:0]         idx, idx_next;       // walking index of the sequencer
  logic [CW-1:0]         pos, pos_next;       // insert target
  logic [DATA_WIDTH-1:0] ins_data, ins_data_next;
  logic [CW-1:0]         idx_inc;

  // Entry memory: one write port, one registered read port
  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  // Result register
  logic                  done_next;
  status_t               res_status, res_status_next;
  logic [CW-1:0]         res_count, res_count_next;
  logic                  res_empty, res_empty_next;
  logic [DATA_WIDTH-1:0] res_elem, res_elem_next;
  logic                  res_last, res_last_next;

  assign idx_inc = idx + CW'(1);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    idx_next        = idx;
    pos_next        = pos;
    ins_data_next   = ins_data;
    done_next       = 1'b0;
    res_status_next = res_status;
    res_count_next  = res_count;
    res_empty_next  = res_empty;
    res_elem_next   = res_elem;
    res_last_next   = res_last;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = idx[AW-1:0];
    mem_raddr       = idx[AW-1:0];
    mem_wdata       = mem_rdata;

    case (state)
      S_IDLE: begin
        if (start) begin
          pos_next        = CW'(position);
          ins_data_next   = DATA_WIDTH'(item);
          // Default: a single rejection transaction with the count unchanged
          res_count_next  = cnt;
          res_empty_next  = (cnt == '0);
          res_elem_next   = '0;
          res_last_next   = 1'b1;
          case (func)
            FUNC_INSERT: begin
              if (cnt == CW'(CAPACITY)) begin
                done_next       = 1'b1;
                res_status_next = ST_FULL;
              end else if (CMPW'(position) > CMPW'(cnt)) begin
                done_next       = 1'b1;
                res_status_next = ST_BAD_POS;
              end else begin
                idx_next   = cnt;
                state_next = S_INS_RD;
              end
            end
            FUNC_ERASE: begin
              if (cnt == '0) begin
                done_next       = 1'b1;
                res_status_next = ST_EMPTY;
              end else if (CMPW'(position) >= CMPW'(cnt)) begin
                done_next       = 1'b1;
                res_status_next = ST_BAD_POS;
              end else begin
                idx_next   = CW'(position);
                state_next = S_ERS_RD;
              end
            end
            FUNC_DISPLAY: begin
              if (cnt == '0) begin
                done_next       = 1'b1;
                res_status_next = ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_DSP_RD;
              end
            end
            default: begin
              done_next       = 1'b1;
              res_status_next = ST_BAD_POS;
            end
          endcase
        end
      end

      // Insert: move entries up from the top until the target slot is free
      S_INS_RD: begin
        if (idx == pos) begin
          mem_we          = 1'b1;
          mem_waddr       = pos[AW-1:0];
          mem_wdata       = ins_data;
          cnt_next        = cnt + CW'(1);
          done_next       = 1'b1;
          res_status_next = ST_OK;
          res_count_next  = cnt + CW'(1);
          res_empty_next  = 1'b0;
          res_elem_next   = '0;
          res_last_next   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(idx - CW'(1));
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        idx_next   = idx - CW'(1);
        state_next = S_INS_RD;
      end

      // Erase: pull later entries down one slot
      S_ERS_RD: begin
        if (idx_inc >= cnt) begin
          cnt_next        = cnt - CW'(1);
          done_next       = 1'b1;
          res_status_next = ST_OK;
          res_count_next  = cnt - CW'(1);
          res_empty_next  = (cnt == CW'(1));
          res_elem_next   = '0;
          res_last_next   = 1'b1;
          state_next      = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = idx_inc[AW-1:0];
          state_next = S_ERS_WR;
        end
      end
      S_ERS_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        idx_next   = idx_inc;
        state_next = S_ERS_RD;
      end

      // Display: read and emit one element per pass
      S_DSP_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx[AW-1:0];
        state_next = S_DSP_OUT;
      end
      S_DSP_OUT: begin
        done_next       = 1'b1;
        res_status_next = ST_OK;
        res_count_next  = cnt;
        res_empty_next  = 1'b0;
        res_elem_next   = mem_rdata;
        res_last_next   = (idx_inc == cnt);
        idx_next        = idx_inc;
        state_next      = (idx_inc == cnt) ? S_IDLE : S_DSP_RD;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pos        <= pos_next;
    ins_data   <= ins_data_next;
    res_status <= res_status_next;
    res_count  <= res_count_next;
    res_empty  <= res_empty_next;
    res_elem   <= res_elem_next;
    res_last   <= res_last_next;
  end

  assign busy     = (state != S_IDLE);
  assign status   = res_status;
  assign count    = COUNT_W'(res_count);
  assign is_empty = res_empty;
  assign element  = ITEM_W'(res_elem);
  assign last     = res_last;

endmodule

// File: sv/plst_checker.sv
// Port-level checker for the positional list store, with its bind.
module plst_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [1:0]                    status,
  input logic [plst_pkg::COUNT_W-1:0]  count,
  input logic                          is_empty,
  input logic [plst_pkg::ITEM_W-1:0]   element,
  input logic                          last
);
  import plst_pkg::*;

  // An accepted command either starts work or answers right away
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command gave neither busy nor a result");

  // More results of a display follow only while the block stays busy
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> busy)
    else $error("non-final result while idle");

  // Rejections are single transactions
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> last)
    else $error("rejected command gave more than one result");

  // Empty flag agrees with the reported count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("is_empty disagrees with count");

  // Empty status carries no element and an empty list
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> (is_empty && (element == '0)))
    else $error("empty status with data or nonzero count");

endmodule

bind positional_list_store plst_checker u_plst_checker (.*);
